// ----- rtl/core/gld_pkg.sv -----
package gld_pkg;

    localparam int TABLE_ENTRIES  = 4096;
    localparam int MAX_CODE_WIDTH = 12;
    localparam int ADDR_W         = 12;
    localparam int DEPTH_W        = 13;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_PULL = 2'd2;

    localparam logic [2:0] ST_PIXEL   = 3'd0;
    localparam logic [2:0] ST_DROPPED = 3'd1;
    localparam logic [2:0] ST_TAKEN   = 3'd2;
    localparam logic [2:0] ST_REFUSED = 3'd3;
    localparam logic [2:0] ST_NEED    = 3'd4;
    localparam logic [2:0] ST_DONE    = 3'd5;
    localparam logic [2:0] ST_BAD     = 3'd6;
    localparam logic [2:0] ST_EARLY   = 3'd7;

    localparam logic REG_MIN_CODE_SIZE = 1'b0;
    localparam logic REG_FRAME_PIXELS  = 1'b1;

    typedef enum logic [2:0] {
        PH_RUN,
        PH_ENDSEEN,
        PH_DRAIN,
        PH_DONE,
        PH_BAD,
        PH_EARLY
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP,
        S_POPW,
        S_DECODE,
        S_WALK,
        S_WALKW,
        S_FINISH,
        S_OUT
    } state_t;

    typedef struct packed {
        logic              tbl_we;
        logic [ADDR_W-1:0] tbl_waddr;
        logic [ADDR_W-1:0] tbl_wprefix;
        logic [7:0]        tbl_wsuffix;
        logic [ADDR_W-1:0] tbl_raddr;
        logic              stk_we;
        logic [ADDR_W-1:0] stk_waddr;
        logic [7:0]        stk_wdata;
        logic [ADDR_W-1:0] stk_raddr;
    } mem_ctl_t;

endpackage

// ----- rtl/core/gld_tables.sv -----
module gld_tables (
    input  logic               clk,
    input  gld_pkg::mem_ctl_t  ctl,
    output logic [gld_pkg::ADDR_W-1:0] rd_prefix,
    output logic [7:0]         rd_suffix,
    output logic [7:0]         rd_stack
);

    logic [gld_pkg::ADDR_W-1:0] prefix_mem [gld_pkg::TABLE_ENTRIES];
    logic [7:0] suffix_mem [gld_pkg::TABLE_ENTRIES];
    logic [7:0] stack_mem [gld_pkg::TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (ctl.tbl_we)
        begin
            prefix_mem[ctl.tbl_waddr] <= ctl.tbl_wprefix;
            suffix_mem[ctl.tbl_waddr] <= ctl.tbl_wsuffix;
        end
        rd_prefix <= prefix_mem[ctl.tbl_raddr];
        rd_suffix <= suffix_mem[ctl.tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.stk_we)
        begin
            stack_mem[ctl.stk_waddr] <= ctl.stk_wdata;
        end
        rd_stack <= stack_mem[ctl.stk_raddr];
    end

endmodule

// ----- rtl/core/gif_lzw_decoder.sv -----
// GIF LZW decoder with a pull interface.
// Input items carry an operation and a data byte on in_valid/in_stall; each
// item yields exactly one result item (status, pixel_index) on
// out_valid/out_stall. Operation 0 pushes one image-data byte, 1 marks the
// end of the data, 2 pulls one pixel.
// Pushes, end marks and unused operations go straight to the result. A pull
// that pops the expansion stack reads it in S_POP and S_POPW; a pull that
// decodes a first code or answers without decoding passes S_POP and S_DECODE.
// A pull that decodes any later code passes S_POP, S_DECODE, then S_WALK and
// S_WALKW for each link of its prefix chain, waiting on the registered table
// read, then S_FINISH. Each clear code takes one more pass through S_DECODE.
// The block takes one item at a time; in_stall is high while an item is at
// work or its result waits, and while a configuration write is offered. The
// result register holds while out_stall is high and the next item is taken
// once it has gone.
// Configuration writes (cfg_valid/cfg_ready) set min_code_size and
// frame_pixels, and restart the stream; the tables keep their contents.
// Reset gives min_code_size 8 and frame_pixels 1 with the stream restarted.
module gif_lzw_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  pixel_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int AW = gld_pkg::ADDR_W;
    localparam int DW = gld_pkg::DEPTH_W;

    gld_pkg::state_t state_reg, state_next;
    gld_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  min_reg, min_next;
    logic [31:0] frame_reg, frame_next;
    logic [19:0] store_reg, store_next;
    logic [4:0]  count_reg, count_next;
    logic [3:0]  width_reg, width_next;
    logic [DW-1:0] free_reg, free_next;
    logic [AW-1:0] prev_reg, prev_next;
    logic        pvalid_reg, pvalid_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [31:0] remain_reg, remain_next;
    logic [AW-1:0] chain_reg, chain_next;
    logic [DW-1:0] sp_reg, sp_next;
    logic [AW-1:0] code_reg, code_next;
    logic        kw_reg, kw_next;
    logic [2:0]  stat_reg, stat_next;
    logic [7:0]  pix_reg, pix_next;

    gld_pkg::mem_ctl_t ctl;
    logic [AW-1:0] rd_prefix;
    logic [7:0]    rd_suffix;
    logic [7:0]    rd_stack;

    gld_tables u_tables (
        .clk       (clk),
        .ctl       (ctl),
        .rd_prefix (rd_prefix),
        .rd_suffix (rd_suffix),
        .rd_stack  (rd_stack)
    );

    logic [12:0] clear_code;
    logic [11:0] code_mask;
    logic [11:0] cur_code;
    logic [3:0]  min_sat;
    logic        accept_in;

    assign clear_code = 13'd1 << min_reg;
    assign code_mask  = 12'((13'd1 << width_reg) - 13'd1);
    assign cur_code   = store_reg[11:0] & code_mask;
    assign accept_in  = in_valid && !in_stall;
    assign in_stall   = (state_reg != gld_pkg::S_IDLE) || cfg_valid;
    assign out_valid  = (state_reg == gld_pkg::S_OUT);
    assign cfg_ready  = (state_reg == gld_pkg::S_IDLE);
    assign status      = stat_reg;
    assign pixel_index = pix_reg;

    always_comb
    begin
        min_sat = cfg_data[3:0];
        if (min_sat < 4'd1)
        begin
            min_sat = 4'd1;
        end
        if (min_sat > 4'(gld_pkg::MAX_CODE_WIDTH - 1))
        begin
            min_sat = 4'(gld_pkg::MAX_CODE_WIDTH - 1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gld_pkg::S_IDLE:
            begin
                if (accept_in)
                begin
                    state_next = (operation == gld_pkg::OP_PULL) ? gld_pkg::S_POP
                                                                 : gld_pkg::S_OUT;
                end
            end
            gld_pkg::S_POP:
            begin
                state_next = (depth_reg != '0) ? gld_pkg::S_POPW : gld_pkg::S_DECODE;
            end
            gld_pkg::S_POPW:   state_next = gld_pkg::S_OUT;
            gld_pkg::S_DECODE:
            begin
                state_next = gld_pkg::S_OUT;
                if (phase_reg == gld_pkg::PH_RUN || phase_reg == gld_pkg::PH_ENDSEEN)
                begin
                    if ({1'b0, count_reg} >= {2'b0, width_reg})
                    begin
                        if ({1'b0, cur_code} == clear_code)
                        begin
                            state_next = gld_pkg::S_DECODE;
                        end
                        else if ({1'b0, cur_code} != clear_code + 13'd1 && pvalid_reg)
                        begin
                            if (!({1'b0, cur_code} > free_reg)
                                && !({1'b0, cur_code} == free_reg
                                     && free_reg >= DW'(gld_pkg::TABLE_ENTRIES)))
                            begin
                                state_next = gld_pkg::S_WALK;
                            end
                        end
                    end
                end
            end
            gld_pkg::S_WALK:
            begin
                if ({1'b0, chain_reg} < clear_code)
                begin
                    state_next = gld_pkg::S_FINISH;
                end
                else if (sp_reg >= DW'(gld_pkg::TABLE_ENTRIES))
                begin
                    state_next = gld_pkg::S_OUT;
                end
                else
                begin
                    state_next = gld_pkg::S_WALKW;
                end
            end
            gld_pkg::S_WALKW:  state_next = gld_pkg::S_WALK;
            gld_pkg::S_FINISH: state_next = gld_pkg::S_OUT;
            gld_pkg::S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = gld_pkg::S_IDLE;
                end
            end
            default: state_next = gld_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        phase_next  = phase_reg;
        min_next    = min_reg;
        frame_next  = frame_reg;
        store_next  = store_reg;
        count_next  = count_reg;
        width_next  = width_reg;
        free_next   = free_reg;
        prev_next   = prev_reg;
        pvalid_next = pvalid_reg;
        depth_next  = depth_reg;
        remain_next = remain_reg;
        chain_next  = chain_reg;
        sp_next     = sp_reg;
        code_next   = code_reg;
        kw_next     = kw_reg;
        stat_next   = stat_reg;
        pix_next    = pix_reg;
        ctl         = '0;
        ctl.tbl_raddr = chain_reg;
        ctl.stk_raddr = AW'(depth_reg - DW'(1));

        case (state_reg)
            gld_pkg::S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_index == gld_pkg::REG_MIN_CODE_SIZE)
                    begin
                        min_next = min_sat;
                    end
                    else
                    begin
                        frame_next = cfg_data;
                    end
                    store_next  = '0;
                    count_next  = '0;
                    width_next  = (cfg_index == gld_pkg::REG_MIN_CODE_SIZE) ? min_sat + 4'd1
                                                                           : min_reg + 4'd1;
                    free_next   = (cfg_index == gld_pkg::REG_MIN_CODE_SIZE)
                                  ? (DW'(1) << min_sat) + DW'(2)
                                  : clear_code + DW'(2);
                    prev_next   = '0;
                    pvalid_next = 1'b0;
                    depth_next  = '0;
                    remain_next = (cfg_index == gld_pkg::REG_FRAME_PIXELS) ? cfg_data
                                                                          : frame_reg;
                    phase_next  = gld_pkg::PH_RUN;
                end
                else if (accept_in)
                begin
                    pix_next  = '0;
                    stat_next = gld_pkg::ST_REFUSED;
                    if (operation == gld_pkg::OP_PUSH)
                    begin
                        if (phase_reg == gld_pkg::PH_DRAIN)
                        begin
                            stat_next = gld_pkg::ST_TAKEN;
                        end
                        else if (phase_reg == gld_pkg::PH_RUN && count_reg <= 5'd12)
                        begin
                            store_next = 20'(store_reg | (20'(data_byte) << count_reg));
                            count_next = count_reg + 5'd8;
                            stat_next  = gld_pkg::ST_TAKEN;
                        end
                    end
                    else if (operation == gld_pkg::OP_END)
                    begin
                        if (phase_reg == gld_pkg::PH_RUN)
                        begin
                            phase_next = gld_pkg::PH_ENDSEEN;
                            stat_next  = gld_pkg::ST_TAKEN;
                        end
                        else if (phase_reg == gld_pkg::PH_DRAIN)
                        begin
                            depth_next = '0;
                            if (remain_reg != '0)
                            begin
                                phase_next = gld_pkg::PH_EARLY;
                                stat_next  = gld_pkg::ST_EARLY;
                            end
                            else
                            begin
                                phase_next = gld_pkg::PH_DONE;
                                stat_next  = gld_pkg::ST_DONE;
                            end
                        end
                    end
                end
            end
            gld_pkg::S_POP:
            begin
                ctl.stk_raddr = AW'(depth_reg - DW'(1));
                if (depth_reg != '0)
                begin
                    depth_next = depth_reg - DW'(1);
                end
            end
            gld_pkg::S_POPW:
            begin
                if (remain_reg == '0)
                begin
                    stat_next = gld_pkg::ST_DROPPED;
                end
                else
                begin
                    remain_next = remain_reg - 32'd1;
                    stat_next   = gld_pkg::ST_PIXEL;
                    pix_next    = rd_stack;
                end
            end
            gld_pkg::S_DECODE:
            begin
                depth_next = '0;
                case (phase_reg)
                    gld_pkg::PH_DONE:  stat_next = gld_pkg::ST_DONE;
                    gld_pkg::PH_BAD:   stat_next = gld_pkg::ST_BAD;
                    gld_pkg::PH_EARLY: stat_next = gld_pkg::ST_EARLY;
                    gld_pkg::PH_DRAIN: stat_next = gld_pkg::ST_NEED;
                    default:
                    begin
                        if ({1'b0, count_reg} < {2'b0, width_reg})
                        begin
                            if (phase_reg == gld_pkg::PH_RUN)
                            begin
                                stat_next = gld_pkg::ST_NEED;
                            end
                            else if (remain_reg != '0)
                            begin
                                phase_next = gld_pkg::PH_EARLY;
                                stat_next  = gld_pkg::ST_EARLY;
                            end
                            else
                            begin
                                phase_next = gld_pkg::PH_DONE;
                                stat_next  = gld_pkg::ST_DONE;
                            end
                        end
                        else
                        begin
                            store_next = store_reg >> width_reg;
                            count_next = count_reg - 5'(width_reg);
                            if ({1'b0, cur_code} == clear_code)
                            begin
                                width_next  = min_reg + 4'd1;
                                free_next   = clear_code + DW'(2);
                                pvalid_next = 1'b0;
                            end
                            else if ({1'b0, cur_code} == clear_code + 13'd1)
                            begin
                                phase_next = gld_pkg::PH_DRAIN;
                                store_next = '0;
                                count_next = '0;
                                stat_next  = gld_pkg::ST_NEED;
                            end
                            else if (!pvalid_reg)
                            begin
                                if ({1'b0, cur_code} >= clear_code)
                                begin
                                    phase_next = gld_pkg::PH_BAD;
                                    stat_next  = gld_pkg::ST_BAD;
                                end
                                else
                                begin
                                    prev_next   = cur_code;
                                    pvalid_next = 1'b1;
                                    if (remain_reg == '0)
                                    begin
                                        stat_next = gld_pkg::ST_DROPPED;
                                    end
                                    else
                                    begin
                                        remain_next = remain_reg - 32'd1;
                                        stat_next   = gld_pkg::ST_PIXEL;
                                        pix_next    = cur_code[7:0];
                                    end
                                end
                            end
                            else if ({1'b0, cur_code} > free_reg
                                     || ({1'b0, cur_code} == free_reg
                                         && free_reg >= DW'(gld_pkg::TABLE_ENTRIES)))
                            begin
                                phase_next = gld_pkg::PH_BAD;
                                stat_next  = gld_pkg::ST_BAD;
                            end
                            else
                            begin
                                code_next  = cur_code;
                                kw_next    = ({1'b0, cur_code} == free_reg);
                                chain_next = ({1'b0, cur_code} == free_reg) ? prev_reg
                                                                            : cur_code;
                                sp_next    = ({1'b0, cur_code} == free_reg) ? DW'(1) : '0;
                            end
                        end
                    end
                endcase
            end
            gld_pkg::S_WALK:
            begin
                ctl.tbl_raddr = chain_reg;
                if ({1'b0, chain_reg} >= clear_code && sp_reg >= DW'(gld_pkg::TABLE_ENTRIES))
                begin
                    phase_next = gld_pkg::PH_BAD;
                    depth_next = '0;
                    stat_next  = gld_pkg::ST_BAD;
                end
            end
            gld_pkg::S_WALKW:
            begin
                ctl.stk_we    = 1'b1;
                ctl.stk_waddr = sp_reg[AW-1:0];
                ctl.stk_wdata = rd_suffix;
                sp_next       = sp_reg + DW'(1);
                chain_next    = rd_prefix;
            end
            gld_pkg::S_FINISH:
            begin
                if (kw_reg)
                begin
                    ctl.stk_we    = 1'b1;
                    ctl.stk_waddr = '0;
                    ctl.stk_wdata = chain_reg[7:0];
                end
                depth_next = sp_reg;
                if (free_reg < DW'(gld_pkg::TABLE_ENTRIES))
                begin
                    ctl.tbl_we      = 1'b1;
                    ctl.tbl_waddr   = free_reg[AW-1:0];
                    ctl.tbl_wprefix = prev_reg;
                    ctl.tbl_wsuffix = chain_reg[7:0];
                    free_next       = free_reg + DW'(1);
                    if (free_reg + DW'(1) == (DW'(1) << width_reg)
                        && width_reg < 4'(gld_pkg::MAX_CODE_WIDTH))
                    begin
                        width_next = width_reg + 4'd1;
                    end
                end
                prev_next = code_reg;
                if (remain_reg == '0)
                begin
                    stat_next = gld_pkg::ST_DROPPED;
                end
                else
                begin
                    remain_next = remain_reg - 32'd1;
                    stat_next   = gld_pkg::ST_PIXEL;
                    pix_next    = chain_reg[7:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= gld_pkg::S_IDLE;
            phase_reg  <= gld_pkg::PH_RUN;
            min_reg    <= 4'd8;
            frame_reg  <= 32'd1;
            store_reg  <= '0;
            count_reg  <= '0;
            width_reg  <= 4'd9;
            free_reg   <= DW'(258);
            prev_reg   <= '0;
            pvalid_reg <= 1'b0;
            depth_reg  <= '0;
            remain_reg <= 32'd1;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            min_reg    <= min_next;
            frame_reg  <= frame_next;
            store_reg  <= store_next;
            count_reg  <= count_next;
            width_reg  <= width_next;
            free_reg   <= free_next;
            prev_reg   <= prev_next;
            pvalid_reg <= pvalid_next;
            depth_reg  <= depth_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
        sp_reg    <= sp_next;
        code_reg  <= code_next;
        kw_reg    <= kw_next;
        stat_reg  <= stat_next;
        pix_reg   <= pix_next;
    end

`ifndef NO_ASSERTIONS
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> in_stall)
        else $error("item accepted while previous item still at work");
    a_pix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != gld_pkg::ST_PIXEL) |-> (pixel_index == 8'd0))
        else $error("pixel index set on a non-pixel result");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 5'd20)
        else $error("bit store overflow");
    a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
        width_reg <= 4'(gld_pkg::MAX_CODE_WIDTH) && width_reg > min_reg)
        else $error("code width out of range");
`endif

endmodule
